// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the stop order trigger table.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SOTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SOTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sott_pkg.sv =====
// Types, codes and default sizes of the stop order trigger table.
// No dependencies.
package sott_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_PRICE_BITS  = 32;
    localparam int DEF_ID_BITS     = 32;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_CANCEL = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK,
        ST_DONE
    } state_t;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
    localparam logic [2:0] KIND_TRIGGERED = 3'd4;
    localparam logic [2:0] KIND_CANCELLED = 3'd5;
    localparam logic [2:0] KIND_NONE      = 3'd6;

    localparam logic [1:0] SRC_LAST  = 2'd1;
    localparam logic [1:0] SRC_INDEX = 2'd2;

endpackage

// ===== design/stop_order_trigger_table.sv =====
// Top level of the stop order trigger table: sequencer, entry RAM and compare unit.
// Depends on sott_pkg, sott_ram and sott_cmp.
//
// A transaction is taken when start is high and busy is low. An add, a price update while
// frozen, and a remove, price update or cancel user on an empty table keep busy high for one
// cycle; the next transaction is taken only once busy is low again. Otherwise remove, price
// update and cancel user walk the table through the single RAM read port, one entry per
// cycle, and keep busy high through state ST_WALK and then ST_DONE. Each result is shown
// for one cycle under result_valid and cannot be held off, since the receiver cannot stall;
// one transaction gives one to TABLE_DEPTH results, the final one with last_item set, in the
// first cycle after busy falls. The table needs no clearing after reset.
module stop_order_trigger_table #(
    parameter int TABLE_DEPTH = sott_pkg::DEF_TABLE_DEPTH,
    parameter int PRICE_BITS  = sott_pkg::DEF_PRICE_BITS,
    parameter int ID_BITS     = sott_pkg::DEF_ID_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [ID_BITS-1:0]    ord_id,
    input  logic [ID_BITS-1:0]    user_id,
    input  logic                  side,
    input  logic [1:0]            trig_src,
    input  logic [PRICE_BITS-1:0] trig_price,
    input  logic [PRICE_BITS-1:0] mark_px,
    input  logic [PRICE_BITS-1:0] last_price,
    input  logic [PRICE_BITS-1:0] index_px,
    input  logic                  frozen,
    output logic                  result_valid,
    output logic [2:0]            kind,
    output logic [ID_BITS-1:0]    out_order_id,
    output logic [ID_BITS-1:0]    out_user_id,
    output logic                  out_side,
    output logic [PRICE_BITS-1:0] out_trigger_price,
    output logic                  last_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 2 * ID_BITS + PRICE_BITS + 3;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    sott_pkg::state_t  state_reg, state_next;
    sott_pkg::action_t action_reg, action_next;

    logic [ID_BITS-1:0]    oid_reg, oid_next, uid_reg, uid_next;
    logic                  side_reg, side_next;
    logic [1:0]            src_reg, src_next;
    logic [PRICE_BITS-1:0] tprice_reg, tprice_next, mark_reg, mark_next;
    logic [PRICE_BITS-1:0] lastp_reg, lastp_next, index_reg, index_next;

    logic [CW-1:0] count_reg, count_next, rd_reg, rd_next, w_reg, w_next;
    logic          vld_reg, vld_next, found_reg, found_next;

    logic                  pend_vld_reg, pend_vld_next;
    logic [2:0]            pend_kind_reg, pend_kind_next;
    logic [ID_BITS-1:0]    pend_oid_reg, pend_oid_next, pend_uid_reg, pend_uid_next;
    logic                  pend_side_reg, pend_side_next;
    logic [PRICE_BITS-1:0] pend_price_reg, pend_price_next;

    logic                  res_vld_reg, res_vld_next, res_last_reg, res_last_next;
    logic [2:0]            res_kind_reg, res_kind_next;
    logic [ID_BITS-1:0]    res_oid_reg, res_oid_next, res_uid_reg, res_uid_next;
    logic                  res_side_reg, res_side_next;
    logic [PRICE_BITS-1:0] res_price_reg, res_price_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [ID_BITS-1:0]    ent_oid, ent_uid;
    logic [PRICE_BITS-1:0] ent_price;
    logic                  ent_side;
    logic [1:0]            ent_src;
    logic                  hit;
    logic [2:0]            hit_kind;

    assign {ent_oid, ent_uid, ent_price, ent_side, ent_src} = ram_rdata;

    sott_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    sott_cmp #(
        .PRICE_BITS (PRICE_BITS),
        .ID_BITS    (ID_BITS)
    ) u_cmp (
        .op          (action_reg),
        .ent_oid     (ent_oid),
        .ent_uid     (ent_uid),
        .ent_price   (ent_price),
        .ent_side    (ent_side),
        .ent_src     (ent_src),
        .cmd_oid     (oid_reg),
        .cmd_uid     (uid_reg),
        .mark_px     (mark_reg),
        .last_price  (lastp_reg),
        .index_px    (index_reg),
        .found       (found_reg),
        .hit         (hit)
    );

    always_comb
    begin
        case (action_reg)
            sott_pkg::ACT_REMOVE: hit_kind = sott_pkg::KIND_REMOVED;
            sott_pkg::ACT_UPDATE: hit_kind = sott_pkg::KIND_TRIGGERED;
            default:              hit_kind = sott_pkg::KIND_CANCELLED;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sott_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (sott_pkg::action_t'(action) == sott_pkg::ACT_ADD)
                    begin
                        state_next = sott_pkg::ST_ADD;
                    end
                    else if ((sott_pkg::action_t'(action) == sott_pkg::ACT_UPDATE && frozen)
                             || count_reg == '0)
                    begin
                        state_next = sott_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = sott_pkg::ST_WALK;
                    end
                end
            end
            sott_pkg::ST_ADD:  state_next = sott_pkg::ST_IDLE;
            sott_pkg::ST_WALK:
            begin
                if (rd_reg == count_reg && !vld_reg)
                begin
                    state_next = sott_pkg::ST_DONE;
                end
            end
            sott_pkg::ST_DONE: state_next = sott_pkg::ST_IDLE;
            default:           state_next = sott_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        action_next     = action_reg;
        oid_next        = oid_reg;
        uid_next        = uid_reg;
        side_next       = side_reg;
        src_next        = src_reg;
        tprice_next     = tprice_reg;
        mark_next       = mark_reg;
        lastp_next      = lastp_reg;
        index_next      = index_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        w_next          = w_reg;
        vld_next        = 1'b0;
        found_next      = found_reg;
        pend_vld_next   = pend_vld_reg;
        pend_kind_next  = pend_kind_reg;
        pend_oid_next   = pend_oid_reg;
        pend_uid_next   = pend_uid_reg;
        pend_side_next  = pend_side_reg;
        pend_price_next = pend_price_reg;
        res_vld_next    = 1'b0;
        res_last_next   = 1'b0;
        res_kind_next   = res_kind_reg;
        res_oid_next    = res_oid_reg;
        res_uid_next    = res_uid_reg;
        res_side_next   = res_side_reg;
        res_price_next  = res_price_reg;
        ram_we          = 1'b0;
        ram_waddr       = w_reg[AW-1:0];
        ram_wdata       = ram_rdata;

        case (state_reg)
            sott_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    action_next   = sott_pkg::action_t'(action);
                    oid_next      = ord_id;
                    uid_next      = user_id;
                    side_next     = side;
                    src_next      = trig_src;
                    tprice_next   = trig_price;
                    mark_next     = mark_px;
                    lastp_next    = last_price;
                    index_next    = index_px;
                    rd_next       = '0;
                    w_next        = (sott_pkg::action_t'(action) == sott_pkg::ACT_UPDATE
                                     && frozen) ? count_reg : '0;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                end
            end
            sott_pkg::ST_ADD:
            begin
                res_vld_next   = 1'b1;
                res_last_next  = 1'b1;
                res_oid_next   = oid_reg;
                res_uid_next   = uid_reg;
                res_side_next  = side_reg;
                res_price_next = tprice_reg;
                if (count_reg == FULL_COUNT)
                begin
                    res_kind_next = sott_pkg::KIND_FULL;
                end
                else
                begin
                    res_kind_next = sott_pkg::KIND_ADDED;
                    ram_we        = 1'b1;
                    ram_waddr     = count_reg[AW-1:0];
                    ram_wdata     = {oid_reg, uid_reg, tprice_reg, side_reg, src_reg};
                    count_next    = count_reg + CW'(1);
                end
            end
            sott_pkg::ST_WALK:
            begin
                if (rd_reg != count_reg)
                begin
                    rd_next  = rd_reg + CW'(1);
                    vld_next = 1'b1;
                end
                if (vld_reg)
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                        if (pend_vld_reg)
                        begin
                            res_vld_next   = 1'b1;
                            res_kind_next  = pend_kind_reg;
                            res_oid_next   = pend_oid_reg;
                            res_uid_next   = pend_uid_reg;
                            res_side_next  = pend_side_reg;
                            res_price_next = pend_price_reg;
                        end
                        pend_vld_next   = 1'b1;
                        pend_kind_next  = hit_kind;
                        pend_oid_next   = ent_oid;
                        pend_uid_next   = ent_uid;
                        pend_side_next  = ent_side;
                        pend_price_next = ent_price;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        w_next = w_reg + CW'(1);
                    end
                end
            end
            sott_pkg::ST_DONE:
            begin
                count_next    = w_reg;
                res_vld_next  = 1'b1;
                res_last_next = 1'b1;
                if (pend_vld_reg)
                begin
                    res_kind_next  = pend_kind_reg;
                    res_oid_next   = pend_oid_reg;
                    res_uid_next   = pend_uid_reg;
                    res_side_next  = pend_side_reg;
                    res_price_next = pend_price_reg;
                end
                else
                begin
                    res_kind_next  = (action_reg == sott_pkg::ACT_REMOVE)
                                     ? sott_pkg::KIND_NOTFOUND : sott_pkg::KIND_NONE;
                    res_oid_next   = (action_reg == sott_pkg::ACT_REMOVE) ? oid_reg : '0;
                    res_uid_next   = '0;
                    res_side_next  = 1'b0;
                    res_price_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sott_pkg::ST_IDLE;
            count_reg    <= '0;
            rd_reg       <= '0;
            w_reg        <= '0;
            vld_reg      <= 1'b0;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_reg       <= rd_next;
            w_reg        <= w_next;
            vld_reg      <= vld_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
            res_last_reg <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        oid_reg        <= oid_next;
        uid_reg        <= uid_next;
        side_reg       <= side_next;
        src_reg        <= src_next;
        tprice_reg     <= tprice_next;
        mark_reg       <= mark_next;
        lastp_reg      <= lastp_next;
        index_reg      <= index_next;
        pend_kind_reg  <= pend_kind_next;
        pend_oid_reg   <= pend_oid_next;
        pend_uid_reg   <= pend_uid_next;
        pend_side_reg  <= pend_side_next;
        pend_price_reg <= pend_price_next;
        res_kind_reg   <= res_kind_next;
        res_oid_reg    <= res_oid_next;
        res_uid_reg    <= res_uid_next;
        res_side_reg   <= res_side_next;
        res_price_reg  <= res_price_next;
    end

    assign busy              = (state_reg != sott_pkg::ST_IDLE);
    assign result_valid      = res_vld_reg;
    assign last_item         = res_last_reg;
    assign kind              = res_kind_reg;
    assign out_order_id      = res_oid_reg;
    assign out_user_id       = res_uid_reg;
    assign out_side          = res_side_reg;
    assign out_trigger_price = res_price_reg;

endmodule

// ===== design/sott_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sott_cmp.sv =====
// Shared compare unit: decides whether one table entry is hit by the current command.
// Depends on sott_pkg.
module sott_cmp #(
    parameter int PRICE_BITS = sott_pkg::DEF_PRICE_BITS,
    parameter int ID_BITS    = sott_pkg::DEF_ID_BITS
) (
    input  sott_pkg::action_t      op,
    input  logic [ID_BITS-1:0]     ent_oid,
    input  logic [ID_BITS-1:0]     ent_uid,
    input  logic [PRICE_BITS-1:0]  ent_price,
    input  logic                   ent_side,
    input  logic [1:0]             ent_src,
    input  logic [ID_BITS-1:0]     cmd_oid,
    input  logic [ID_BITS-1:0]     cmd_uid,
    input  logic [PRICE_BITS-1:0]  mark_px,
    input  logic [PRICE_BITS-1:0]  last_price,
    input  logic [PRICE_BITS-1:0]  index_px,
    input  logic                   found,
    output logic                   hit
);

    logic [PRICE_BITS-1:0] sel_price;

    always_comb
    begin
        case (ent_src)
            sott_pkg::SRC_LAST:  sel_price = last_price;
            sott_pkg::SRC_INDEX: sel_price = index_px;
            default:             sel_price = mark_px;
        endcase
    end

    always_comb
    begin
        case (op)
            sott_pkg::ACT_REMOVE: hit = (ent_oid == cmd_oid) && !found;
            sott_pkg::ACT_UPDATE: hit = ent_side ? (sel_price <= ent_price)
                                                 : (sel_price >= ent_price);
            sott_pkg::ACT_CANCEL: hit = (ent_uid == cmd_uid);
            default:              hit = 1'b0;
        endcase
    end

endmodule

// ===== design/sott_checker.sv =====
// Port level checks of the stop order trigger table, bound to the top level.
// Depends on sott_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sott_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [2:0] kind,
    input logic       last_item
);

    logic accept;
    logic kind_ok;
    logic single_res;
    logic mid_res;

    assign accept     = start && !busy;
    assign kind_ok    = (kind <= sott_pkg::KIND_NONE);
    assign single_res = result_valid && ((kind == sott_pkg::KIND_ADDED)
                        || (kind == sott_pkg::KIND_FULL) || (kind == sott_pkg::KIND_REMOVED)
                        || (kind == sott_pkg::KIND_NOTFOUND) || (kind == sott_pkg::KIND_NONE));
    assign mid_res    = result_valid && !last_item;

    `SOTT_ASSERT_NEXT(a_start_busy, clk, rst_n, accept, busy, "busy not raised after accept")
    `SOTT_ASSERT_NOW(a_kind_range, clk, rst_n, result_valid, kind_ok, "result kind out of range")
    `SOTT_ASSERT_NOW(a_single_last, clk, rst_n, single_res, last_item, "last_item missing")
    `SOTT_ASSERT_NOW(a_more_busy, clk, rst_n, mid_res, busy, "results pending while idle")

endmodule

bind stop_order_trigger_table sott_checker u_sott_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .last_item    (last_item)
);

// ===== bench/sott_checker.sv =====
// Scoreboard for the stop order trigger table: mirrors the table, predicts results and compares.
// Depends on sott_pkg; watches the command and result ports of the block.
module sott_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] ord_id,
    input  logic [31:0] user_id,
    input  logic        side,
    input  logic [1:0]  trig_src,
    input  logic [31:0] trig_price,
    input  logic [31:0] mark_px,
    input  logic [31:0] last_price,
    input  logic [31:0] index_px,
    input  logic        frozen,
    input  logic        result_valid,
    input  logic [2:0]  kind,
    input  logic [31:0] out_order_id,
    input  logic [31:0] out_user_id,
    input  logic        out_side,
    input  logic [31:0] out_trigger_price,
    input  logic        last_item,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = sott_pkg::DEF_TABLE_DEPTH;

    typedef struct packed {
        logic [31:0] oid;
        logic [31:0] uid;
        logic        sd;
        logic [1:0]  src;
        logic [31:0] price;
    } stop_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] oid;
        logic [31:0] uid;
        logic        sd;
        logic [31:0] price;
        logic        last;
    } stop_result_t;

    stop_entry_t  book[$];
    stop_result_t expected_results[$];

    function automatic stop_result_t make_result(logic [2:0] k, logic [31:0] oid,
                                                 logic [31:0] uid, logic sd,
                                                 logic [31:0] price);
        stop_result_t r;
        r.kind = k;
        r.oid = oid;
        r.uid = uid;
        r.sd = sd;
        r.price = price;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_transaction();
        stop_result_t batch[$];
        stop_entry_t  kept[$];
        stop_entry_t  e;
        logic [31:0]  sel_price;
        logic         hit;
        logic         upd;
        int           idx;
        idx = -1;
        upd = (action == sott_pkg::ACT_UPDATE);
        case (sott_pkg::action_t'(action))
            sott_pkg::ACT_ADD:
            begin
                if (book.size() >= DEPTH)
                    batch.insert(batch.size(), make_result(sott_pkg::KIND_FULL, ord_id,
                                 user_id, side, trig_price));
                else
                begin
                    e = '{ord_id, user_id, side, trig_src, trig_price};
                    book.insert(book.size(), e);
                    batch.insert(batch.size(), make_result(sott_pkg::KIND_ADDED, ord_id,
                                 user_id, side, trig_price));
                end
            end
            sott_pkg::ACT_REMOVE:
            begin
                foreach (book[i])
                    if (idx < 0 && book[i].oid == ord_id)
                        idx = i;
                if (idx < 0)
                    batch.insert(batch.size(), make_result(sott_pkg::KIND_NOTFOUND, ord_id,
                                 '0, 1'b0, '0));
                else
                begin
                    e = book[idx];
                    batch.insert(batch.size(), make_result(sott_pkg::KIND_REMOVED, e.oid,
                                 e.uid, e.sd, e.price));
                    book.delete(idx);
                end
            end
            default:
            begin
                if (!(upd && frozen))
                begin
                    foreach (book[i])
                    begin
                        e = book[i];
                        if (upd)
                        begin
                            sel_price = (e.src == sott_pkg::SRC_LAST) ? last_price :
                                        (e.src == sott_pkg::SRC_INDEX) ? index_px : mark_px;
                            hit = e.sd ? (sel_price <= e.price) : (sel_price >= e.price);
                        end
                        else
                            hit = (e.uid == user_id);
                        if (hit)
                            batch.insert(batch.size(), make_result(upd ?
                                sott_pkg::KIND_TRIGGERED : sott_pkg::KIND_CANCELLED,
                                e.oid, e.uid, e.sd, e.price));
                        else
                            kept.insert(kept.size(), e);
                    end
                    book = kept;
                end
                if (batch.size() == 0)
                    batch.insert(0, make_result(sott_pkg::KIND_NONE, '0, '0, 1'b0, '0));
            end
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_results.insert(expected_results.size(), batch[i]);
    endtask

    initial
    begin
        fail_count = 0;
        result_count = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        stop_result_t got;
        stop_result_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                result_count++;
                got = '{kind, out_order_id, out_user_id, out_side, out_trigger_price,
                        last_item};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %p", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch, expected %p, actual %p",
                                     $time, want, got);
                    end
                end
            end
            if (start && !busy)
                predict_transaction();
            pending_count = expected_results.size();
        end
    end
endmodule

// ===== bench/tb_stop_order_trigger_table.sv =====
// Top of the stop order trigger table testbench: clock, reset, stimulus and verdict.
// Depends on sott_pkg, the block and sott_scoreboard.
module tb_stop_order_trigger_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = sott_pkg::ACT_ADD;
    logic [31:0] ord_id = '0;
    logic [31:0] user_id = '0;
    logic        side = 1'b0;
    logic [1:0]  trig_src = '0;
    logic [31:0] trig_price = '0;
    logic [31:0] mark_px = '0;
    logic [31:0] last_price = '0;
    logic [31:0] index_px = '0;
    logic        frozen = 1'b0;
    logic        result_valid;
    logic [2:0]  kind;
    logic [31:0] out_order_id;
    logic [31:0] out_user_id;
    logic        out_side;
    logic [31:0] out_trigger_price;
    logic        last_item;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_cycles = 0;
    int          sent_count = 0;
    logic [31:0] used_ids[$];
    logic [31:0] used_users[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stop_order_trigger_table DUT (.*);

    sott_scoreboard scoreboard_i (.*);

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] pick_price();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 32'd1000 + $urandom_range(0, 40);
        endcase
    endfunction

    task automatic send_transaction(logic [1:0] act, logic [31:0] oid, logic [31:0] uid,
                                    logic sd, logic [1:0] src, logic [31:0] tp,
                                    logic [31:0] mp, logic [31:0] lp, logic [31:0] ip,
                                    logic frz);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        repeat (gap) @(negedge clk);
        action = act;
        ord_id = oid;
        user_id = uid;
        side = sd;
        trig_src = src;
        trig_price = tp;
        mark_px = mp;
        last_price = lp;
        index_px = ip;
        frozen = frz;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
        sent_count++;
        if (act == sott_pkg::ACT_ADD)
        begin
            used_ids.insert(used_ids.size(), oid);
            used_users.insert(used_users.size(), uid);
        end
    endtask

    task automatic send_random();
        logic [31:0] oid;
        logic [31:0] uid;
        logic [31:0] new_oid;
        logic        sd;
        logic [1:0]  src;
        logic        frz;
        int          r;
        r = $urandom_range(0, 99);
        oid = (used_ids.size() > 0 && $urandom_range(0, 3) != 0) ?
              used_ids[$urandom_range(0, used_ids.size() - 1)] : $urandom();
        uid = (used_users.size() > 0 && $urandom_range(0, 2) != 0) ?
              used_users[$urandom_range(0, used_users.size() - 1)] :
              ($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom());
        new_oid = $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom();
        sd = 1'($urandom_range(0, 1));
        src = 2'($urandom_range(0, 3));
        frz = 1'($urandom_range(0, 1));
        if (r < 45)
            send_transaction(sott_pkg::ACT_ADD, new_oid, uid, sd, src, pick_price(),
                             $urandom(), $urandom(), $urandom(), frz);
        else if (r < 62)
            send_transaction(sott_pkg::ACT_REMOVE, oid, $urandom(), sd, src, $urandom(),
                             $urandom(), $urandom(), $urandom(), frz);
        else if (r < 88)
            send_transaction(sott_pkg::ACT_UPDATE, $urandom(), $urandom(), sd, src, $urandom(),
                             pick_price(), pick_price(), pick_price(),
                             $urandom_range(0, 5) == 0);
        else
            send_transaction(sott_pkg::ACT_CANCEL, $urandom(), uid, sd, src, $urandom(),
                             $urandom(), $urandom(), $urandom(), frz);
    endtask

    initial
    begin
        int wait_cycles;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_transaction(sott_pkg::ACT_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_transaction(sott_pkg::ACT_CANCEL, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        send_transaction(sott_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_transaction(sott_pkg::ACT_ADD, (i == 3) ? 32'd1 : i,
                             (i < 2) ? 32'hFFFF_FFFF : i % 3,
                             i[0], i[1:0], (i == 0) ? 32'hFFFF_FFFF : 32'd100 + i,
                             0, 0, 0, i[2]);
        send_transaction(sott_pkg::ACT_REMOVE, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_transaction(sott_pkg::ACT_UPDATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1'b1);
        send_transaction(sott_pkg::ACT_UPDATE, 0, 0, 0, 0, 0, 32'd105, 32'd0, 32'hFFFF_FFFF,
                         1'b0);
        send_transaction(sott_pkg::ACT_CANCEL, 0, 32'd2, 0, 0, 0, 0, 0, 0, 0);
        send_transaction(sott_pkg::ACT_UPDATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 1'b0);

        while (sent_count < 430)
            send_random();

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (25) @(posedge clk);
        $display("Drove %0d adds, removes, price updates and cancels; checked %0d results.",
                 sent_count, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/sott_pkg.sv
design/sott_ram.sv
design/sott_cmp.sv
design/stop_order_trigger_table.sv
design/sott_checker.sv
bench/sott_checker.sv
bench/tb_stop_order_trigger_table.sv
